FILE: rtl/core/tlpq_pkg.sv
// tlpq_pkg: shared types and constants for the tree LCA / path query core.
// No dependencies.
package tlpq_pkg;
	localparam int SUM_BITS  = 41;
	localparam int EDGE_BITS = 11;
	localparam logic [SUM_BITS-1:0]  SUM_MAX  = {SUM_BITS{1'b1}};
	localparam logic [EDGE_BITS-1:0] EDGE_MAX = {EDGE_BITS{1'b1}};

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// datapath commands
	localparam int CMD_BITS = 4;
	localparam logic [CMD_BITS-1:0] CMD_NOP      = 4'd0;
	localparam logic [CMD_BITS-1:0] CMD_CAPTURE  = 4'd1;  // latch input beat
	localparam logic [CMD_BITS-1:0] CMD_LV_RD    = 4'd2;  // read levels
	localparam logic [CMD_BITS-1:0] CMD_LD_ROOT  = 4'd3;  // write root row, level
	localparam logic [CMD_BITS-1:0] CMD_LD_BASE  = 4'd4;  // write level and row 0
	localparam logic [CMD_BITS-1:0] CMD_LD_RDP   = 4'd5;  // read row j-1 of node
	localparam logic [CMD_BITS-1:0] CMD_LD_RDA   = 4'd6;  // read row j-1 of ancestor
	localparam logic [CMD_BITS-1:0] CMD_LD_WR    = 4'd7;  // write row j
	localparam logic [CMD_BITS-1:0] CMD_Q_SWAP   = 4'd8;  // order by level
	localparam logic [CMD_BITS-1:0] CMD_Q_RD     = 4'd9;  // read level i for u and v
	localparam logic [CMD_BITS-1:0] CMD_Q_LIFT   = 4'd10; // climb u
	localparam logic [CMD_BITS-1:0] CMD_Q_PAIR   = 4'd11; // climb both
	localparam logic [CMD_BITS-1:0] CMD_Q_FINAL  = 4'd12; // final parent edges

	typedef struct packed {
		logic [CMD_BITS-1:0] cmd;
		logic [3:0]          lvl;
	} tlpq_cmd_t;

	typedef struct packed {
		logic mode;
		logic is_root;
		logic same;     // u == v after lift
	} tlpq_stat_t;
endpackage

FILE: rtl/core/tree_lca_path_query_core.sv
// Tree LCA / path query core: controller and datapath, with jump-table memories.
// Depends on tlpq_pkg, tlpq_ctrl, tlpq_datapath, tlpq_ram.
//
// A node load (mode 0) is bounded by one jump-RAM read port: each jump row
// needs the node's row, then its ancestor's row, then a write. A query
// (mode 1) makes two level passes of a read and a use each, then a read and
// a use for the final parent edges; when the nodes meet during the first
// pass the second pass is skipped. Its result beat is held on out_valid
// until taken, and the next input beat is accepted once it leaves. Loads
// give no result beat. Parents must be loaded before children.
module tree_lca_path_query_core #(
	parameter int NODES       = 1024,
	parameter int LEVELS      = 10,
	parameter int WEIGHT_BITS = 31
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [9:0]  node,
	input  logic [9:0]  partner,
	input  logic        is_root,
	input  logic [30:0] edge_weight,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [9:0]  ancestor,
	output logic [30:0] min_edge,
	output logic [40:0] path_total,
	output logic [10:0] path_edges
);
	tlpq_pkg::tlpq_cmd_t  cmd;
	tlpq_pkg::tlpq_stat_t stat;

	tlpq_ctrl #(.LEVELS(LEVELS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .stat(stat));

	tlpq_datapath #(.NODES(NODES), .LEVELS(LEVELS), .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
		.clk(clk), .cmd(cmd), .stat(stat), .mode(mode), .node(node), .partner(partner),
		.is_root(is_root), .edge_weight(edge_weight), .ancestor(ancestor),
		.min_edge(min_edge), .path_total(path_total), .path_edges(path_edges));

	// no new beat while a result waits
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");

	// result holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(path_total))
		else $error("result dropped");

	// no edges on the path means no weight on it
	a_edges_even_eq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && path_edges == 11'd0 |-> path_total == 41'd0)
		else $error("empty path with nonzero total");
endmodule

FILE: rtl/core/tlpq_ram.sv
// tlpq_ram: generic single-port-write, one-read RAM with registered read.
// No dependencies.
module tlpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/core/tlpq_datapath.sv
// tlpq_datapath: level and jump tables plus query accumulators.
// Depends on tlpq_pkg and tlpq_ram.
module tlpq_datapath #(
	parameter int NODES       = 1024,
	parameter int LEVELS      = 10,
	parameter int WEIGHT_BITS = 31,
	parameter int NB          = (NODES > 1) ? $clog2(NODES) : 1,
	parameter int LB          = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
	input  logic                     clk,
	input  tlpq_pkg::tlpq_cmd_t      cmd,
	output tlpq_pkg::tlpq_stat_t     stat,
	input  logic                     mode,
	input  logic [9:0]               node,
	input  logic [9:0]               partner,
	input  logic                     is_root,
	input  logic [30:0]              edge_weight,
	output logic [9:0]               ancestor,
	output logic [30:0]              min_edge,
	output logic [40:0]              path_total,
	output logic [10:0]              path_edges
);
	localparam int SB    = tlpq_pkg::SUM_BITS;
	localparam int EB    = tlpq_pkg::EDGE_BITS;
	localparam int DEPTH = NODES * LEVELS;
	localparam int AB    = $clog2(DEPTH);
	// entry: ok, parent, min, sum
	localparam int JW    = 1 + NB + WEIGHT_BITS + SB;
	localparam logic [WEIGHT_BITS-1:0] WMAX = {WEIGHT_BITS{1'b1}};

	typedef struct packed {
		logic                   ok;
		logic [NB-1:0]          par;
		logic [WEIGHT_BITS-1:0] mn;
		logic [SB-1:0]          sum;
	} jent_t;

	logic                   mode_q, root_q;
	logic [NB-1:0]          u_q, v_q;
	logic [WEIGHT_BITS-1:0] w_q;
	jent_t                  p_q;
	logic [WEIGHT_BITS-1:0] mn_q;
	logic [SB-1:0]          tot_q;
	logic [EB-1:0]          edges_q;
	logic [NB-1:0]          d_q;
	logic [NB-1:0]          anc_q;

	// level RAM, two read ports by two copies
	logic          lv_we;
	logic [NB-1:0] lv_wdata, lv_ra, lv_rb;
	// jump RAM, two copies for u and v reads
	logic          j_we;
	logic [AB-1:0] j_waddr, j_ra, j_rb;
	jent_t         j_wdata, j_a, j_b;
	logic [JW-1:0] j_a_raw, j_b_raw;

	tlpq_ram #(.WIDTH(NB), .DEPTH(NODES)) u_lva (
		.clk(clk), .we(lv_we), .waddr(u_q), .wdata(lv_wdata), .raddr(u_q), .rdata(lv_ra));
	tlpq_ram #(.WIDTH(NB), .DEPTH(NODES)) u_lvb (
		.clk(clk), .we(lv_we), .waddr(u_q), .wdata(lv_wdata), .raddr(v_q), .rdata(lv_rb));
	tlpq_ram #(.WIDTH(JW), .DEPTH(DEPTH)) u_ja (
		.clk(clk), .we(j_we), .waddr(j_waddr), .wdata(j_wdata), .raddr(j_ra), .rdata(j_a_raw));
	tlpq_ram #(.WIDTH(JW), .DEPTH(DEPTH)) u_jb (
		.clk(clk), .we(j_we), .waddr(j_waddr), .wdata(j_wdata), .raddr(j_rb), .rdata(j_b_raw));

	assign j_a = jent_t'(j_a_raw);
	assign j_b = jent_t'(j_b_raw);

	function automatic logic [AB-1:0] slot(input logic [NB-1:0] n, input logic [LB-1:0] j);
		return AB'(n * LEVELS) + AB'(j);
	endfunction

	function automatic logic [SB-1:0] sadd(input logic [SB-1:0] a, input logic [SB-1:0] b);
		logic [SB:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SB] ? tlpq_pkg::SUM_MAX : s[SB-1:0];
	endfunction

	function automatic logic [EB-1:0] eadd(input logic [EB-1:0] a, input logic [EB:0] b);
		logic [EB+1:0] s;
		s = {2'b0, a} + {1'b0, b};
		return (s > (EB+2)'(tlpq_pkg::EDGE_MAX)) ? tlpq_pkg::EDGE_MAX : s[EB-1:0];
	endfunction

	function automatic logic [WEIGHT_BITS-1:0] wmin(input logic [WEIGHT_BITS-1:0] a,
			input logic [WEIGHT_BITS-1:0] b);
		return (a < b) ? a : b;
	endfunction

	logic [LB-1:0] lvl;
	logic [LB-1:0] lvm1;
	logic [EB:0]   step;
	logic [NB:0]   step_n;
	assign lvl    = LB'(cmd.lvl);
	assign lvm1   = LB'(cmd.lvl - 4'd1);
	assign step   = (EB+1)'(1) << cmd.lvl;
	assign step_n = (NB+1)'(1) << cmd.lvl;

	// memory ports
	always_comb begin
		lv_we    = 1'b0;
		lv_wdata = '0;
		j_we     = 1'b0;
		j_waddr  = slot(u_q, lvl);
		j_wdata  = '0;
		j_ra     = slot(u_q, lvl);
		j_rb     = slot(v_q, lvl);
		unique case (cmd.cmd)
			tlpq_pkg::CMD_LD_ROOT: begin
				lv_we   = 1'b1;
				j_we    = 1'b1;
				j_wdata = '{ok: 1'b0, par: '0, mn: WMAX, sum: '0};
			end
			tlpq_pkg::CMD_LD_BASE: begin
				lv_we    = 1'b1;
				lv_wdata = (lv_rb == NB'(NODES - 1)) ? lv_rb : lv_rb + NB'(1);
				j_we     = 1'b1;
				j_wdata  = '{ok: 1'b1, par: v_q, mn: w_q, sum: SB'(w_q)};
			end
			tlpq_pkg::CMD_LD_RDP: j_ra = slot(u_q, lvm1);
			tlpq_pkg::CMD_LD_RDA: j_ra = slot(j_a.par, lvm1);
			tlpq_pkg::CMD_LD_WR: begin
				j_we = 1'b1;
				if (p_q.ok && j_a.ok) begin
					j_wdata = '{ok: 1'b1, par: j_a.par, mn: wmin(j_a.mn, p_q.mn),
						sum: sadd(j_a.sum, p_q.sum)};
				end else begin
					j_wdata = '{ok: 1'b0, par: '0, mn: WMAX, sum: '0};
				end
			end
			tlpq_pkg::CMD_Q_FINAL: begin
				j_ra = slot(u_q, '0);
				j_rb = slot(v_q, '0);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (cmd.cmd)
			tlpq_pkg::CMD_CAPTURE: begin
				mode_q  <= mode;
				root_q  <= is_root;
				u_q     <= NB'(node);
				v_q     <= NB'(partner);
				w_q     <= WEIGHT_BITS'(edge_weight);
				mn_q    <= WMAX;
				tot_q   <= '0;
				edges_q <= '0;
			end
			tlpq_pkg::CMD_LD_RDA: p_q <= j_a;
			tlpq_pkg::CMD_Q_SWAP: begin
				if (lv_ra < lv_rb) begin
					u_q <= v_q;
					v_q <= u_q;
					d_q <= lv_rb - lv_ra;
				end else begin
					d_q <= lv_ra - lv_rb;
				end
			end
			tlpq_pkg::CMD_Q_LIFT: begin
				if ({1'b0, d_q} >= step_n && j_a.ok) begin
					mn_q    <= wmin(mn_q, j_a.mn);
					tot_q   <= sadd(tot_q, j_a.sum);
					edges_q <= eadd(edges_q, step);
					u_q     <= j_a.par;
					d_q     <= d_q - NB'(step_n);
				end
			end
			tlpq_pkg::CMD_Q_PAIR: begin
				if (j_a.ok && j_b.ok && j_a.par != j_b.par) begin
					mn_q    <= wmin(mn_q, wmin(j_a.mn, j_b.mn));
					tot_q   <= sadd(tot_q, sadd(j_a.sum, j_b.sum));
					edges_q <= eadd(eadd(edges_q, step), step);
					u_q     <= j_a.par;
					v_q     <= j_b.par;
				end
			end
			tlpq_pkg::CMD_Q_FINAL: begin
				if (u_q == v_q) begin
					anc_q <= u_q;
				end else begin
					anc_q <= j_a.ok ? j_a.par : u_q;
					if (j_a.ok && j_b.ok) begin
						mn_q    <= wmin(mn_q, wmin(j_a.mn, j_b.mn));
						tot_q   <= sadd(tot_q, sadd(j_a.sum, j_b.sum));
						edges_q <= eadd(edges_q, (EB+1)'(2));
					end else if (j_a.ok) begin
						mn_q    <= wmin(mn_q, j_a.mn);
						tot_q   <= sadd(tot_q, j_a.sum);
						edges_q <= eadd(edges_q, (EB+1)'(1));
					end else if (j_b.ok) begin
						mn_q    <= wmin(mn_q, j_b.mn);
						tot_q   <= sadd(tot_q, j_b.sum);
						edges_q <= eadd(edges_q, (EB+1)'(1));
					end
				end
			end
			default: ;
		endcase
	end

	assign stat = '{mode: mode_q, is_root: root_q, same: (u_q == v_q)};

	assign ancestor   = 10'(anc_q);
	assign min_edge   = 31'(mn_q);
	assign path_total = tot_q;
	assign path_edges = edges_q;
endmodule

FILE: rtl/core/tlpq_ctrl.sv
// tlpq_ctrl: sequencer for node loads and path queries, output handshake.
// Depends on tlpq_pkg.
module tlpq_ctrl #(
	parameter int LEVELS = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output tlpq_pkg::tlpq_cmd_t  cmd,
	input  tlpq_pkg::tlpq_stat_t stat
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_LVRD  = 4'd1;
	localparam logic [3:0] S_LVUSE = 4'd2;
	localparam logic [3:0] S_RDP   = 4'd3;
	localparam logic [3:0] S_WR    = 4'd5;
	localparam logic [3:0] S_LRD   = 4'd6;
	localparam logic [3:0] S_LIFT  = 4'd7;
	localparam logic [3:0] S_PRD   = 4'd8;
	localparam logic [3:0] S_PAIR  = 4'd9;
	localparam logic [3:0] S_FRD   = 4'd10;
	localparam logic [3:0] S_FIN   = 4'd11;
	localparam logic [3:0] S_WAIT  = 4'd12;
	localparam logic [3:0] S_RDP2  = 4'd13;

	localparam logic [3:0] TOP = 4'(LEVELS - 1);

	logic [3:0] state_q, state_d;
	logic [3:0] lvl_q, lvl_d;
	logic       ov_q, ov_d;

	assign in_ready  = (state_q == S_IDLE) && !ov_q;
	assign out_valid = ov_q;

	always_comb begin
		state_d = state_q;
		lvl_d   = lvl_q;
		ov_d    = ov_q && !out_ready;
		cmd     = '{cmd: tlpq_pkg::CMD_NOP, lvl: lvl_q};
		unique case (state_q)
			S_IDLE: if (in_valid && in_ready) begin
				cmd.cmd = tlpq_pkg::CMD_CAPTURE;
				state_d = S_LVRD;
			end
			S_LVRD: begin
				cmd.cmd = tlpq_pkg::CMD_LV_RD;
				state_d = S_LVUSE;
			end
			S_LVUSE: begin
				if (stat.mode == tlpq_pkg::MODE_QUERY) begin
					cmd.cmd = tlpq_pkg::CMD_Q_SWAP;
					lvl_d   = TOP;
					state_d = S_LRD;
				end else if (stat.is_root) begin
					cmd.cmd = tlpq_pkg::CMD_LD_ROOT;
					cmd.lvl = 4'd0;
					lvl_d   = 4'd1;
					state_d = (LEVELS > 1) ? S_WR : S_IDLE;
				end else begin
					cmd.cmd = tlpq_pkg::CMD_LD_BASE;
					cmd.lvl = 4'd0;
					lvl_d   = 4'd1;
					state_d = (LEVELS > 1) ? S_RDP : S_IDLE;
				end
			end
			S_RDP: begin
				cmd.cmd = tlpq_pkg::CMD_LD_RDP;
				state_d = S_RDP2;
			end
			S_RDP2: begin
				// node row j-1 now on read port; fetch ancestor row
				cmd.cmd = tlpq_pkg::CMD_LD_RDA;
				state_d = S_WR;
			end
			S_WR: begin
				// root rows reuse this state, writing an invalid jump entry at each level
				cmd.cmd = stat.is_root ? tlpq_pkg::CMD_LD_ROOT : tlpq_pkg::CMD_LD_WR;
				if (lvl_q == TOP) begin
					state_d = S_IDLE;
				end else begin
					lvl_d   = lvl_q + 4'd1;
					state_d = stat.is_root ? S_WR : S_RDP;
				end
			end
			S_LRD: begin
				cmd.cmd = tlpq_pkg::CMD_Q_RD;
				state_d = S_LIFT;
			end
			S_LIFT: begin
				cmd.cmd = tlpq_pkg::CMD_Q_LIFT;
				if (lvl_q == 4'd0) begin
					lvl_d   = TOP;
					state_d = S_PRD;
				end else begin
					lvl_d   = lvl_q - 4'd1;
					state_d = S_LRD;
				end
			end
			S_PRD: begin
				cmd.cmd = tlpq_pkg::CMD_Q_RD;
				state_d = stat.same ? S_FRD : S_PAIR;
			end
			S_PAIR: begin
				cmd.cmd = tlpq_pkg::CMD_Q_PAIR;
				if (lvl_q == 4'd0) begin
					state_d = S_FRD;
				end else begin
					lvl_d   = lvl_q - 4'd1;
					state_d = S_PRD;
				end
			end
			S_FRD: begin
				// fetch row 0 of both sides
				cmd.cmd = tlpq_pkg::CMD_Q_RD;
				cmd.lvl = 4'd0;
				state_d = S_FIN;
			end
			S_FIN: begin
				cmd.cmd = tlpq_pkg::CMD_Q_FINAL;
				cmd.lvl = 4'd0;
				state_d = S_WAIT;
			end
			S_WAIT: begin
				ov_d    = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			lvl_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			lvl_q   <= lvl_d;
			ov_q    <= ov_d;
		end
	end
endmodule
